FILE: src/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, item type and round helpers.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: src/sha256_item_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short register queue between the intake and the compression engine.
// ----------------------------------------------------------------------------
module sha256_item_fifo
    import sha256_pkg::*;
#(
    parameter int Depth = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    item_t             mem_reg [Depth];
    logic [Aw-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [Aw:0]       cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == (Aw+1)'(Depth));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == Aw'(Depth - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == Aw'(Depth - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (Aw+1)'(Depth))
        else $error("queue count overflow");
    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not rise");
    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count did not fall");

endmodule

FILE: src/sha256_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine
// Packs bytes, pads, runs one round per cycle and emits the digest words.
// ----------------------------------------------------------------------------
module sha256_engine
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_take,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StRound = 3'd1;
    localparam logic [2:0] StAdd   = 3'd2;
    localparam logic [2:0] StPad   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic        final_reg;   // compression is the last one of the message
    logic        pad2_reg;    // pad block without length, a second one follows
    logic        next_reg;    // padding goes on after this compression
    logic        lead_reg;    // pad byte still to be placed at the fill slot
    logic [2:0]  out_reg;

    logic [31:0] s0w, s1w, wnew, wcur;
    logic [31:0] big0, big1, ch, maj, t1, t2;
    logic [5:0]  pos;
    logic [1:0]  lane;
    logic [3:0]  word_idx;

    assign wcur = w_reg[0];
    assign s0w  = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1w  = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + s0w + w_reg[9] + s1w;
    assign big1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + RoundK[round_reg] + wcur;
    assign big0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    assign pos      = fill_reg;
    assign word_idx = pos[5:2];
    assign lane     = pos[1:0];

    assign item_take   = (state_reg == StIdle) && item_valid;
    assign empty       = (state_reg != StOut);
    assign digest_word = h_reg[out_reg];
    assign word_number = out_reg;
    assign final_word  = (out_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (item_valid)
                begin
                    if (item.byte_present && fill_reg == 6'd63)
                    begin
                        state_next = StRound;
                    end
                    else if (item.end_of_message)
                    begin
                        state_next = StPad;
                    end
                end
            end
            StRound:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = StAdd;
                end
            end
            StAdd:
            begin
                if (final_reg)
                begin
                    state_next = StOut;
                end
                else if (next_reg)
                begin
                    state_next = StPad;
                end
                else
                begin
                    state_next = StIdle;
                end
            end
            StPad:
            begin
                // one byte slot a cycle until the block is ready
                if (pad2_reg && pos == 6'd63)
                begin
                    state_next = StRound;
                end
                else if (!pad2_reg && pos == 6'd55)
                begin
                    state_next = StRound;
                end
            end
            StOut:
            begin
                if (pop && out_reg == 3'd7)
                begin
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            pad2_reg  <= 1'b0;
            next_reg  <= 1'b0;
            lead_reg  <= 1'b0;
            out_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                StIdle:
                begin
                    if (item_valid)
                    begin
                        if (item.byte_present)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (item.byte_present && fill_reg == 6'd63)
                        begin
                            // full block; a closing byte leaves padding for a new block
                            final_reg <= 1'b0;
                            pad2_reg  <= 1'b0;
                            next_reg  <= item.end_of_message;
                            lead_reg  <= item.end_of_message;
                        end
                        else if (item.end_of_message)
                        begin
                            // pad byte goes into the slot after the last byte
                            lead_reg <= 1'b1;
                            next_reg <= 1'b0;
                            pad2_reg <= ((item.byte_present ? fill_reg + 6'd1 : fill_reg)
                                         >= 6'd56);
                        end
                    end
                end
                StRound:
                begin
                    round_reg <= round_reg + 1'b1;
                end
                StAdd:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                StPad:
                begin
                    fill_reg <= pos + 1'b1;
                    lead_reg <= 1'b0;
                    if ((pad2_reg && pos == 6'd63) || (!pad2_reg && pos == 6'd55))
                    begin
                        final_reg <= !pad2_reg;
                        next_reg  <= pad2_reg;
                        pad2_reg  <= 1'b0;
                        fill_reg  <= '0;
                    end
                end
                StOut:
                begin
                    if (pop)
                    begin
                        out_reg <= out_reg + 1'b1;
                        if (out_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= InitHash[i];
                            end
                            bits_reg  <= '0;
                            fill_reg  <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == StIdle && item_valid)
        begin
            if (item.byte_present)
            begin
                w_reg[word_idx][(3 - lane) * 8 +: 8] <= item.data_byte;
            end
            if (item.byte_present && fill_reg == 6'd63)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end
        else if (state_reg == StPad)
        begin
            if (pos <= 6'd55 || pad2_reg)
            begin
                w_reg[word_idx][(3 - lane) * 8 +: 8] <= lead_reg ? PadByte : 8'h00;
            end
            if ((pad2_reg && pos == 6'd63) || (!pad2_reg && pos == 6'd55))
            begin
                if (!pad2_reg)
                begin
                    w_reg[14] <= bits_reg[63:32];
                    w_reg[15] <= bits_reg[31:0];
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end
        else if (state_reg == StRound)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> state_reg == StIdle)
        else $error("item taken while busy");
    a_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StIdle) |-> round_reg == 6'd0)
        else $error("round count not zero between blocks");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StOut && pop && out_reg == 3'd7) |=> state_reg == StIdle)
        else $error("digest drain did not finish");

endmodule

FILE: src/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and emits the 256-bit digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each transaction carries data_byte, byte_present
// and end_of_message. A transaction with end_of_message set closes the
// message (byte_present low hashes without adding a byte).
// A small queue decouples intake from the engine, so a few bytes are
// absorbed while a block is being compressed.
// Engine: a stored byte is taken only while the engine is idle; the 64th byte
// of a block starts the compression rounds (one round per cycle) and an add
// step. Closing a message walks the pad slots one per cycle, up to 56, or
// up to 8 and then 56 more, with one or two compressions.
// Result channel: empty/pop. Eight transactions carry digest_word 0..7,
// word_number and final_word on the last. A stalled receiver holds the
// engine in its output phase; the queue then fills and full is raised.
// After the eighth word the hash state returns to the initial values.
// Reset clears all control state at once.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit
    import sha256_pkg::*;
#(
    parameter int QueueDepth = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);
    item_t in_item, q_item;
    logic  q_empty, q_take;

    assign in_item = '{data_byte: data_byte, byte_present: byte_present,
                       end_of_message: end_of_message};

    sha256_item_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (full),
        .pop       (q_take),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    sha256_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (!q_empty),
        .item        (q_item),
        .item_take   (q_take),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_number (word_number),
        .final_word  (final_word)
    );

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !final_word) |=> !empty && word_number == $past(word_number) + 3'd1)
        else $error("digest words out of order");
    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> final_word == (word_number == 3'd7))
        else $error("final flag mismatch");
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> word_number == 3'd0)
        else $error("digest does not start at word zero");

endmodule
